// ===== rtl/pata_pkg.sv =====
// Shared types and constants for the primitive assembly block.
// Depends on nothing; used by every module of the block.
package pata_pkg;

    localparam logic [2:0] PRIM_LIST   = 3'd3;
    localparam logic [2:0] PRIM_STRIP  = 3'd4;
    localparam logic [2:0] PRIM_FAN    = 3'd5;
    localparam logic [2:0] PRIM_SPRITE = 3'd6;

    localparam logic [1:0] JOB_LIST   = 2'd0;
    localparam logic [1:0] JOB_TRI    = 2'd1;
    localparam logic [1:0] JOB_SPRITE = 2'd2;

    // First member sits in the highest bits, so x lands in the lowest bits.
    typedef struct packed {
        logic [63:0] uv;
        logic [63:0] ba;
        logic [63:0] rg;
        logic [31:0] w;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } vertex_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] mode;
        vertex_t    a;
        vertex_t    b;
        vertex_t    c;
    } job_t;

    function automatic logic [2:0] job_len(input logic [1:0] mode);
        logic [2:0] len;
        case (mode)
            JOB_TRI:    len = 3'd3;
            JOB_SPRITE: len = 3'd6;
            default:    len = 3'd1;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/pata_history.sv =====
// Vertex history and primitive tracking; builds one emit job per transfer.
// Depends on pata_pkg.
module pata_history
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [2:0]        cmd_prim,
    input  logic              first_of_primitive,
    input  pata_pkg::vertex_t cur,
    output pata_pkg::job_t    job
);

    pata_pkg::vertex_t first_reg, older_reg, prev_reg;
    logic [1:0] seen_reg, seen_next;
    logic       parity_reg;
    logic [2:0] prim_reg;

    logic [1:0] cnt;
    logic       par;
    logic [2:0] prim;

    assign cnt  = first_of_primitive ? 2'd0 : seen_reg;
    assign par  = first_of_primitive ? 1'b0 : parity_reg;
    assign prim = first_of_primitive ? cmd_prim : prim_reg;
    assign seen_next = (cnt == 2'd3) ? 2'd3 : cnt + 2'd1;

    always_comb
    begin
        job       = '0;
        job.a     = prev_reg;
        job.b     = older_reg;
        job.c     = cur;
        job.mode  = pata_pkg::JOB_LIST;
        case (prim)
            pata_pkg::PRIM_LIST:
            begin
                job.valid = 1'b1;
            end
            pata_pkg::PRIM_STRIP:
            begin
                job.valid = (cnt >= 2'd2);
                job.mode  = pata_pkg::JOB_TRI;
                job.a     = par ? prev_reg : older_reg;
                job.b     = par ? older_reg : prev_reg;
            end
            pata_pkg::PRIM_FAN:
            begin
                job.valid = (cnt >= 2'd2);
                job.mode  = pata_pkg::JOB_TRI;
                job.a     = first_reg;
                job.b     = prev_reg;
            end
            pata_pkg::PRIM_SPRITE:
            begin
                job.valid = par && (cnt >= 2'd1);
                job.mode  = pata_pkg::JOB_SPRITE;
            end
            default:
            begin
                job.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= 2'd0;
            parity_reg <= 1'b0;
            prim_reg   <= 3'd0;
        end
        else if (accept)
        begin
            seen_reg   <= seen_next;
            parity_reg <= ~par;
            prim_reg   <= prim;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (cnt == 2'd0)
            begin
                first_reg <= cur;
            end
            older_reg <= prev_reg;
            prev_reg  <= cur;
        end
    end

endmodule

// ===== rtl/pata_emit.sv =====
// Job register, step sequencer and output register for emitted vertices.
// Depends on pata_pkg.
module pata_emit
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  pata_pkg::job_t job_in,
    output logic           job_ready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [319:0]   m_tdata,
    output logic           m_tlast
);

    pata_pkg::job_t    job_reg;
    logic              job_valid_reg, job_valid_next;
    logic [2:0]        step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    pata_pkg::vertex_t out_data_reg;
    logic              out_last_reg;

    pata_pkg::vertex_t sel;
    logic              out_free;
    logic              advance;
    logic              last_step;

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = job_valid_reg && out_free;
    assign last_step = (step_reg == pata_pkg::job_len(job_reg.mode) - 3'd1);
    assign job_ready = !job_valid_reg || (advance && last_step);

    always_comb
    begin
        sel = job_reg.c;
        if (job_reg.mode == pata_pkg::JOB_TRI)
        begin
            case (step_reg)
                3'd0:    sel = job_reg.a;
                3'd1:    sel = job_reg.b;
                default: sel = job_reg.c;
            endcase
        end
        else if (job_reg.mode == pata_pkg::JOB_SPRITE)
        begin
            case (step_reg)
                3'd0:
                begin
                    sel = job_reg.a;
                end
                3'd1:
                begin
                    sel   = job_reg.a;
                    sel.y = job_reg.c.y;
                end
                3'd3:
                begin
                    sel = job_reg.a;
                end
                3'd5:
                begin
                    sel   = job_reg.c;
                    sel.y = job_reg.a.y;
                end
                default:
                begin
                    sel = job_reg.c;
                end
            endcase
        end
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (last_step)
            begin
                job_valid_next = 1'b0;
                step_next      = 3'd0;
            end
            else
            begin
                step_next = step_reg + 3'd1;
            end
        end
        if (load && job_ready)
        begin
            job_valid_next = job_in.valid;
            step_next      = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && job_ready)
        begin
            job_reg <= job_in;
        end
        if (advance)
        begin
            out_data_reg <= sel;
            out_last_reg <= last_step;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/primitive_assembly_to_triangle_list.sv =====
// Top level of the primitive assembly block: vertices in, triangle list out.
// Depends on pata_pkg, pata_history and pata_emit.
//
//  Channel | Direction | Carries
//  --------+-----------+---------------------------------------------------
//  s_*     | in        | one vertex with primitive type and start mark
//  m_*     | out       | one vertex of the triangle list, tlast on the last
//
// A list vertex emits one vertex, a strip or fan vertex three and a sprite pair six; a vertex
// that emits nothing frees the job register; the output takes one vertex per cycle when not stalled.
// An input transfer loads a job register; the next input is taken in the cycle
// the last vertex of the current job moves into the output register.
// Reset clears the primitive state and all valid flags; no clearing pass.
// A stalled output holds its vertex and backs up into the job register.
module primitive_assembly_to_triangle_list
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [319:0] s_tdata,   // pos_x, pos_y, pos_z, pos_w, color_rg, color_ba, tex_uv
    input  logic [3:0]   s_tuser,   // cmd_prim, first_of_primitive
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [319:0] m_tdata,   // out_x, out_y, out_z, out_w, out_rg, out_ba, out_uv
    output logic         m_tlast
);

    pata_pkg::job_t    job;
    pata_pkg::vertex_t cur;
    logic              accept;
    logic              job_ready;

    assign cur      = s_tdata;
    assign s_tready = job_ready;
    assign accept   = s_tvalid && job_ready;

    pata_history u_history
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .cmd_prim           (s_tuser[2:0]),
        .first_of_primitive (s_tuser[3]),
        .cur                (cur),
        .job                (job)
    );

    pata_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .job_in    (job),
        .job_ready (job_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
